### rtl/tkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_pkg
// Shared types and constants for the keyed result cache.
// ----------------------------------------------------------------------------
package tkc_pkg;

  localparam logic [15:0] TTL_RESET = 16'd300;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_CHK,
    ST_CMP_RD,
    ST_CMP_EQ,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic meta_rd;
    logic chk;
    logic next_slot;
    logic victim_cur;
    logic victim_min;
    logic clr_j;
    logic byte_rd;
    logic byte_next;
    logic set_hit;
    logic copy_rd;
    logic copy_wr;
    logic load_out;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic op_err;
    logic is_store;
    logic used_cur;
    logic len_eq;
    logic byte_eq;
    logic last_byte;
    logic last_slot;
    logic out_free;
  } sts_t;

endpackage

### rtl/tkc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_ctrl
// Sequencer that walks the slots, compares keys and copies keys being stored.
// ----------------------------------------------------------------------------
module tkc_ctrl
  import tkc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (sts.in_valid && sts.in_last) begin
          state_next = ST_META;
        end
      end
      ST_META: begin
        if (sts.op_err) begin
          state_next = ST_RESULT;
        end else begin
          ctl.meta_rd = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        ctl.chk = 1'b1;
        if (!sts.used_cur && sts.is_store) begin
          ctl.victim_cur = 1'b1;
          ctl.clr_j = 1'b1;
          state_next = ST_COPY_RD;
        end else if (sts.used_cur && sts.len_eq) begin
          ctl.clr_j = 1'b1;
          state_next = ST_CMP_RD;
        end else if (!sts.last_slot) begin
          ctl.next_slot = 1'b1;
          state_next = ST_META;
        end else if (sts.is_store) begin
          ctl.victim_min = 1'b1;
          ctl.clr_j = 1'b1;
          state_next = ST_COPY_RD;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_CMP_RD: begin
        ctl.byte_rd = 1'b1;
        state_next = ST_CMP_EQ;
      end
      ST_CMP_EQ: begin
        if (sts.byte_eq && !sts.last_byte) begin
          ctl.byte_next = 1'b1;
          state_next = ST_CMP_RD;
        end else if (sts.byte_eq && !sts.is_store) begin
          ctl.set_hit = 1'b1;
          state_next = ST_RESULT;
        end else if (sts.byte_eq) begin
          ctl.victim_cur = 1'b1;
          ctl.clr_j = 1'b1;
          state_next = ST_COPY_RD;
        end else if (!sts.last_slot) begin
          ctl.next_slot = 1'b1;
          state_next = ST_META;
        end else if (sts.is_store) begin
          ctl.victim_min = 1'b1;
          ctl.clr_j = 1'b1;
          state_next = ST_COPY_RD;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_COPY_RD: begin
        ctl.copy_rd = 1'b1;
        state_next = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        ctl.copy_wr = 1'b1;
        if (sts.last_byte) begin
          state_next = ST_RESULT;
        end else begin
          ctl.byte_next = 1'b1;
          state_next = ST_COPY_RD;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/tkc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_dpath
// Key buffer, slot stores, scan counters, age check and output register.
// ----------------------------------------------------------------------------
module tkc_dpath
  import tkc_pkg::*;
#(
  parameter int SLOTS   = 32,
  parameter int KEY_MAX = 96
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic        in_valid,
  input  logic        cmd,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic [31:0] now,
  input  logic [1:0]  reach_in,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        hit,
  output logic [1:0]  reach_out,
  output logic        key_error
);

  localparam int KEY_CAP = KEY_MAX - 1;
  localparam int LW = $clog2(KEY_MAX + 1);
  localparam int KA = (KEY_CAP > 1) ? $clog2(KEY_CAP) : 1;
  localparam int SW = $clog2(SLOTS);
  localparam int BW = (SLOTS * KEY_CAP > 1) ? $clog2(SLOTS * KEY_CAP) : 1;

  logic [7:0]    pend_mem [KEY_CAP];
  logic [7:0]    key_mem  [SLOTS * KEY_CAP];
  logic [LW-1:0] len_mem  [SLOTS];
  logic [1:0]    reach_mem[SLOTS];
  logic [31:0]   stamp_mem[SLOTS];
  logic [SLOTS-1:0] used;

  logic [15:0]   ttl;
  logic [LW-1:0] pend_len;
  logic          op_cmd;
  logic          op_err;
  logic [LW-1:0] op_len;
  logic [31:0]   op_now;
  logic [1:0]    op_reach;

  logic [SW-1:0] s;
  logic [BW-1:0] base;
  logic [LW-1:0] j;
  logic          first;
  logic [31:0]   min_stamp;
  logic [SW-1:0] min_s;
  logic [BW-1:0] min_base;
  logic [SW-1:0] victim;
  logic [BW-1:0] vbase;
  logic          hit_flag;

  logic [7:0]    pk_q;
  logic [7:0]    sk_q;
  logic [LW-1:0] len_q;
  logic [1:0]    reach_q;
  logic [31:0]   stamp_q;

  logic          acc;
  logic          cand;
  logic [SW-1:0] min_s_eff;
  logic [BW-1:0] min_base_eff;
  logic [BW-1:0] rd_addr;
  logic [BW-1:0] wr_addr;
  logic [31:0]   age;

  assign acc = in_valid && ctl.in_ready;
  assign cand = ctl.chk && (first || (stamp_q < min_stamp));
  assign min_s_eff = cand ? s : min_s;
  assign min_base_eff = cand ? base : min_base;
  assign rd_addr = BW'({{LW{1'b0}}, base} + {{BW{1'b0}}, j});
  assign wr_addr = BW'({{LW{1'b0}}, vbase} + {{BW{1'b0}}, j});
  assign age = op_now - stamp_q;

  assign sts.in_valid  = in_valid;
  assign sts.in_last   = key_last;
  assign sts.op_err    = op_err;
  assign sts.is_store  = (op_cmd == OP_STORE);
  assign sts.used_cur  = used[s];
  assign sts.len_eq    = (len_q == op_len);
  assign sts.byte_eq   = (pk_q == sk_q);
  assign sts.last_byte = (j == op_len - LW'(1));
  assign sts.last_slot = (s == SW'(SLOTS - 1));
  assign sts.out_free  = !out_valid || out_ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl      <= TTL_RESET;
      pend_len <= '0;
      used     <= '0;
    end else begin
      if (cfg_we) begin
        ttl <= cfg_wdata;
      end
      if (acc) begin
        if (key_last) begin
          pend_len <= '0;
        end else if (pend_len < LW'(KEY_MAX)) begin
          pend_len <= pend_len + LW'(1);
        end
      end
      if (ctl.copy_wr) begin
        used[victim] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      key_error <= op_err;
      hit       <= hit_flag;
      reach_out <= hit_flag ? reach_q : 2'd0;
    end
  end

  // Operation capture and scan registers.
  always_ff @(posedge clk) begin
    if (acc && key_last) begin
      op_cmd   <= cmd;
      op_err   <= (pend_len >= LW'(KEY_CAP));
      op_len   <= (pend_len < LW'(KEY_MAX)) ? pend_len + LW'(1) : pend_len;
      op_now   <= now;
      op_reach <= (reach_in == 2'd3) ? 2'd0 : reach_in;
      s        <= '0;
      base     <= '0;
      first    <= 1'b1;
      hit_flag <= 1'b0;
    end
    if (ctl.chk) begin
      first     <= 1'b0;
      min_stamp <= cand ? stamp_q : min_stamp;
      min_s     <= min_s_eff;
      min_base  <= min_base_eff;
    end
    if (ctl.next_slot) begin
      s    <= s + SW'(1);
      base <= base + BW'(KEY_CAP);
    end
    if (ctl.victim_cur) begin
      victim <= s;
      vbase  <= base;
    end
    if (ctl.victim_min) begin
      victim <= min_s_eff;
      vbase  <= min_base_eff;
    end
    if (ctl.clr_j) begin
      j <= '0;
    end else if (ctl.byte_next) begin
      j <= j + LW'(1);
    end
    if (ctl.set_hit) begin
      hit_flag <= (age <= {16'd0, ttl});
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (acc && (pend_len < LW'(KEY_CAP))) begin
      pend_mem[pend_len[KA-1:0]] <= key_byte;
    end
    if (ctl.byte_rd || ctl.copy_rd) begin
      pk_q <= pend_mem[j[KA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.copy_wr) begin
      key_mem[wr_addr] <= pk_q;
    end
    if (ctl.byte_rd) begin
      sk_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.copy_wr) begin
      len_mem[victim]   <= op_len;
      reach_mem[victim] <= op_reach;
      stamp_mem[victim] <= op_now;
    end
    if (ctl.meta_rd) begin
      len_q   <= len_mem[s];
      reach_q <= reach_mem[s];
      stamp_q <= stamp_mem[s];
    end
  end

endmodule

### rtl/ttl_keyed_result_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_keyed_result_cache
// Small cache of byte-string keys with a reach code and an age limit.
// ----------------------------------------------------------------------------
// Keys arrive one byte per input beat on a valid/ready channel; the beat with
// key_last set also carries the command (lookup or store), the current time
// and, for a store, the reach code. A byte that is not the last one gives
// no result. The last byte gives exactly one result beat: hit and reach_out
// for a lookup, all zero for a store, and key_error alone for a key longer
// than KEY_MAX-1 bytes, which leaves the cache alone.
// After the last byte the block walks the slots in order: a header read and
// a check per slot, plus a read and a compare per compared key byte, and for
// a store a read and a write per byte copied into the chosen slot. Input is
// held off until the result has been placed in the output register.
// The output register holds the result while the receiver stalls; the next
// key's bytes are already accepted meanwhile, and only the completion of that
// key waits for the register to free up. Reset empties every slot and sets
// ttl to 300. The user must write the TTL register through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ttl_keyed_result_cache
  import tkc_pkg::*;
#(
  parameter int SLOTS   = 32,
  parameter int KEY_MAX = 96
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic [31:0] now,
  input  logic [1:0]  reach_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [1:0]  reach_out,
  output logic        key_error,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  ctl_t ctl;
  sts_t sts;

  // The sequencer decides every step; the datapath only obeys and reports.
  tkc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  tkc_dpath #(
    .SLOTS   (SLOTS),
    .KEY_MAX (KEY_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .key_byte  (key_byte),
    .key_last  (key_last),
    .now       (now),
    .reach_in  (reach_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .hit       (hit),
    .reach_out (reach_out),
    .key_error (key_error)
  );

  assign in_ready = ctl.in_ready;

  // An over-long key can never report a hit.
  a_err_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(key_error && hit))
    else $error("key_error and hit both set");

  // A miss or a store reports the indeterminate reach code.
  a_miss_reach: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (reach_out == 2'd0))
    else $error("reach_out set without a hit");

  // Code 3 is never stored, so it is never returned.
  a_reach_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reach_out != 2'd3))
    else $error("reach_out carries code 3");

  // No new key is taken while a result is being worked out.
  a_busy_no_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && key_last) |=> !in_ready)
    else $error("input accepted during slot walk");

endmodule

### bench/ttl_keyed_result_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_keyed_result_cache_test
// Self-checking bench for the keyed result cache.
// ----------------------------------------------------------------------------
// Key bytes are sent as input beats through one shared task. A predictor in
// the bench keeps its own copy of the slots and works out the result of every
// key-ending beat. A checker process compares each result beat with the
// oldest prediction. Each named test task covers one area of behaviour, and
// the tasks run in turn from one initial block.
// ----------------------------------------------------------------------------
module ttl_keyed_result_cache_test;
  import tkc_pkg::*;

  localparam int SLOTS   = 32;
  localparam int KEY_MAX = 96;
  localparam int KEY_CAP = KEY_MAX - 1;
  // Enough cycles for the slowest single key to finish its slot walk.
  localparam int DRAIN_CYCLES = 2 * SLOTS * (2 + 2 * KEY_CAP) + 64;

  typedef struct packed {
    logic       hit;
    logic [1:0] reach;
    logic       key_error;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = OP_LOOKUP;
  logic [7:0]  key_byte = 8'd0;
  logic        key_last = 1'b0;
  logic [31:0] now = 32'd0;
  logic [1:0]  reach_in = 2'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [1:0]  reach_out;
  logic        key_error;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  // Idling percentages for each side, and a long hold-off on the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_cycles = 0;
  int unsigned errors = 0;
  // Set while in_valid is being held high by the sender.
  bit          driving = 1'b0;

  // The predictor's copy of the cache.
  logic [7:0]  key_buf [KEY_CAP];
  int unsigned key_count;
  logic [7:0]  slot_bytes [SLOTS][KEY_CAP];
  int unsigned slot_len [SLOTS];
  logic [1:0]  slot_code [SLOTS];
  logic [31:0] slot_time [SLOTS];
  logic        slot_live [SLOTS];
  logic [15:0] ttl_limit;

  cache_result_t pending_results [$];

  // A small pool of keys so that stores and lookups meet one another often.
  logic [7:0]  pool_bytes [8][KEY_CAP];
  int unsigned pool_len [8];
  logic [31:0] clock_now;

  ttl_keyed_result_cache #(.SLOTS(SLOTS), .KEY_MAX(KEY_MAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .key_byte(key_byte), .key_last(key_last),
    .now(now), .reach_in(reach_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .reach_out(reach_out), .key_error(key_error),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic bit key_equal(int unsigned s, int unsigned len);
    if (!slot_live[s] || slot_len[s] != len) return 1'b0;
    for (int unsigned i = 0; i < len; i++)
      if (slot_bytes[s][i] != key_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Predicts the cache's answer to one accepted beat and updates its copy.
  task automatic predict_cache(input logic c, input logic [7:0] b, input logic l,
                               input logic [31:0] t, input logic [1:0] r);
    cache_result_t res;
    int unsigned   len;
    int unsigned   victim;
    bit            found;
    if (key_count < KEY_CAP) key_buf[key_count] = b;
    if (key_count < KEY_MAX) key_count++;
    if (!l) return;
    len = key_count;
    key_count = 0;
    res = '0;
    found = 1'b0;
    victim = 0;
    if (len > KEY_CAP) begin
      res.key_error = 1'b1;
    end else if (c == OP_LOOKUP) begin
      for (int unsigned s = 0; s < SLOTS; s++) begin
        if (key_equal(s, len)) begin
          // The age wraps modulo 2^32, so a clock that steps back misses.
          if (32'(t - slot_time[s]) <= {16'd0, ttl_limit}) begin
            res.hit = 1'b1;
            res.reach = slot_code[s];
          end
          break;
        end
      end
    end else begin
      for (int unsigned s = 0; s < SLOTS; s++) begin
        if (!slot_live[s] || key_equal(s, len)) begin
          victim = s;
          found = 1'b1;
          break;
        end
      end
      if (!found)
        for (int unsigned s = 1; s < SLOTS; s++)
          if (slot_time[s] < slot_time[victim]) victim = s;
      for (int unsigned i = 0; i < len; i++) slot_bytes[victim][i] = key_buf[i];
      slot_len[victim] = len;
      slot_code[victim] = (r == 2'd3) ? 2'd0 : r;
      slot_time[victim] = t;
      slot_live[victim] = 1'b1;
    end
    pending_results.push_back(res);
  endtask

  // Drops valid when the last beat has gone and no beat follows at once.
  task automatic stop_sending();
    if (driving) begin
      in_valid <= 1'b0;
      driving = 1'b0;
    end
  endtask

  // Sends one beat, idling beforehand at the sender's rate, and predicts it.
  task automatic send_beat(input logic c, input logic [7:0] b, input logic l,
                           input logic [31:0] t, input logic [1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      stop_sending();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    driving = 1'b1;
    cmd <= c;
    key_byte <= b;
    key_last <= l;
    now <= t;
    reach_in <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cache(c, b, l, t, r);
  endtask

  // Sends a whole key with the command on its last byte.
  task automatic send_key(input logic c, input logic [7:0] k [KEY_CAP],
                          input int unsigned len, input logic [31:0] t,
                          input logic [1:0] r);
    for (int unsigned i = 0; i < len; i++)
      send_beat(i == len - 1 ? c : logic'($urandom_range(1)), k[i], i == len - 1,
                t, i == len - 1 ? r : 2'($urandom_range(3)));
  endtask

  task automatic wait_idle();
    int unsigned n;
    n = 0;
    stop_sending();
    while (pending_results.size() != 0 || recv_hold_cycles != 0) @(posedge clk);
    while (n < DRAIN_CYCLES) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic write_ttl(input logic [15:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ttl_limit = v;
  endtask

  function automatic void fill_pool();
    for (int p = 0; p < 8; p++) begin
      // Mostly short keys keep the slot walk quick; one pool entry is long.
      pool_len[p] = (p == 7) ? $urandom_range(KEY_CAP, 40) : $urandom_range(4, 1);
      for (int i = 0; i < KEY_CAP; i++) pool_bytes[p][i] = 8'($urandom);
    end
  endfunction

  // Directed: extremes of the bytes, the longest key, a key one byte too
  // long, stores and lookups, reach code 3 and a clock that steps back.
  task automatic test_directed();
    logic [7:0] k [KEY_CAP];
    for (int i = 0; i < KEY_CAP; i++) k[i] = 8'hFF;
    send_key(OP_LOOKUP, k, 1, 32'd0, 2'd0);
    send_key(OP_STORE, k, 1, 32'd1000, 2'd3);
    send_key(OP_LOOKUP, k, 1, 32'd1300, 2'd0);
    send_key(OP_LOOKUP, k, 1, 32'd1301, 2'd0);
    send_key(OP_LOOKUP, k, 1, 32'd999, 2'd0);
    for (int i = 0; i < KEY_CAP; i++) k[i] = 8'h00;
    send_key(OP_STORE, k, 2, 32'hFFFF_FFFF, 2'd2);
    send_key(OP_LOOKUP, k, 2, 32'hFFFF_FFFF, 2'd1);
    send_key(OP_STORE, k, KEY_CAP, 32'd5, 2'd1);
    send_key(OP_LOOKUP, k, KEY_CAP, 32'd5, 2'd0);
    send_key(OP_STORE, k, KEY_MAX, 32'd6, 2'd1);
    send_key(OP_LOOKUP, k, KEY_MAX + 3, 32'd6, 2'd1);
  endtask

  // Random traffic over the key pool, with noise keys and over-long keys.
  task automatic test_random(input int unsigned keys);
    logic [7:0]  k [KEY_CAP];
    int unsigned p;
    int unsigned len;
    for (int unsigned n = 0; n < keys; n++) begin
      p = $urandom_range(7);
      len = pool_len[p];
      for (int i = 0; i < KEY_CAP; i++) k[i] = pool_bytes[p][i];
      if ($urandom_range(19) == 0) begin
        for (int i = 0; i < KEY_CAP; i++) k[i] = 8'($urandom);
        len = $urandom_range(3, 1);
      end
      if ($urandom_range(200) == 0) len = $urandom_range(KEY_MAX + 2, KEY_MAX);
      clock_now = ($urandom_range(15) == 0) ? 32'($urandom)
                                            : clock_now + $urandom_range(200);
      send_key(logic'($urandom_range(1)), k, len, clock_now, 2'($urandom_range(3)));
    end
  endtask

  // Enough stores of fresh keys to fill every slot and force oldest eviction.
  task automatic test_eviction();
    logic [7:0] k [KEY_CAP];
    for (int n = 0; n < SLOTS + 8; n++) begin
      k[0] = 8'(n);
      k[1] = 8'hA5;
      send_key(OP_STORE, k, 2, 32'($urandom_range(50)), 2'($urandom_range(2)));
    end
    for (int n = 0; n < SLOTS + 8; n++) begin
      k[0] = 8'(n);
      k[1] = 8'hA5;
      send_key(OP_LOOKUP, k, 2, 32'd60, 2'd0);
    end
  endtask

  // The receiver holds off for a long stretch while keys keep coming, so the
  // output register fills and the input is stalled.
  task automatic test_backpressure();
    recv_hold_cycles = 3000;
    test_random(20);
    // The sender then pauses until every prediction has been met.
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The receiver, with its random idling and the long hold-off counted here.
  always @(posedge clk) begin
    if (recv_hold_cycles != 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat hit=%b reach=%0d key_error=%b",
                 $time, hit, reach_out, key_error);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
          errors++;
        end
        if (reach_out !== want.reach) begin
          $display("%0t: reach_out expected %0d actual %0d", $time, want.reach,
                   reach_out);
          errors++;
        end
        if (key_error !== want.key_error) begin
          $display("%0t: key_error expected %b actual %b", $time, want.key_error,
                   key_error);
          errors++;
        end
      end
    end
  end

  initial begin
    key_count = 0;
    ttl_limit = TTL_RESET;
    clock_now = 32'd0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_live[s] = 1'b0;
      slot_len[s] = 0;
      slot_code[s] = 2'd0;
      slot_time[s] = 32'd0;
    end
    fill_pool();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 80;
    test_directed();
    write_ttl(16'd0);
    test_eviction();
    test_random(35);
    write_ttl(16'hFFFF);
    send_idle_pct = 80;
    recv_idle_pct = 6;
    test_random(35);
    test_backpressure();
    write_ttl(16'd100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(30);
    write_ttl(TTL_RESET);
    test_random(20);

    wait_idle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
